/* rtl/rledc_pkg.sv */
// Shared constants and control types for the run-length decoder with CRC check.
package rledc_pkg;

    // Maximum bytes per data transaction on the output
    localparam int LANE_BYTES = 8;
    localparam int LANES      = (LANE_BYTES < 1) ? 1 : ((LANE_BYTES > 8) ? 8 : LANE_BYTES);

    // Field widths
    localparam int LEN_W  = 21;
    localparam int CRC_W  = 16;
    localparam int CFG_W  = 21;
    localparam int IDX_W  = 2;
    localparam int CNT_W  = 8;

    // Command byte fields
    localparam logic [7:0] CMD_COUNT_MASK = 8'h7f;
    localparam logic [7:0] CMD_RUN_FLAG   = 8'h80;

    // CRC-16 polynomial
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_OUTPUT_LENGTH = 2'd0;
    localparam logic [IDX_W-1:0] REG_EXPECTED_CRC  = 2'd1;
    localparam logic [IDX_W-1:0] REG_CRC_SEED      = 2'd2;

    // Reset values of the configuration registers
    localparam logic [LEN_W-1:0] OUTPUT_LENGTH_RST = 21'd65536;
    localparam logic [CRC_W-1:0] EXPECTED_CRC_RST  = 16'h0000;
    localparam logic [CRC_W-1:0] CRC_SEED_RST      = 16'hffff;

    // Decode phases
    localparam logic [1:0] PH_CMD = 2'd0;
    localparam logic [1:0] PH_RUN = 2'd1;
    localparam logic [1:0] PH_LIT = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_TRUNC    = 3'd3;
    localparam logic [2:0] ST_LENGTH   = 3'd4;
    localparam logic [2:0] ST_CRC      = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic cmd_decode;
        logic lit_emit;
        logic run_emit;
        logic crc_step;
        logic status_emit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] phase;
        logic       err_set;
        logic       last;
        logic       run_left_zero;
        logic       crc_cnt_one;
        logic       out_free;
    } t_dp_sts;

endpackage

/* rtl/rledc_ctrl.sv */
// Sequencing controller for the run-length decoder.
module rledc_ctrl
    import rledc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_PROC    = 2'd1;
    localparam logic [1:0] S_RUN_CRC = 2'd2;
    localparam logic [1:0] S_STATUS  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic [1:0] w_after;

    // Where to go once an input transaction has been fully handled
    assign w_after = i_sts.last ? S_STATUS : S_IDLE;

    // Take a new transaction only when idle
    assign o_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_PROC;
                end
            end
            S_PROC: begin
                if (i_sts.err_set) begin
                    n_state = w_after;
                end else begin
                    case (i_sts.phase)
                        PH_CMD: begin
                            o_cmd.cmd_decode = 1'b1;
                            n_state          = w_after;
                        end
                        PH_LIT: begin
                            if (i_sts.out_free) begin
                                o_cmd.lit_emit = 1'b1;
                                n_state        = w_after;
                            end
                        end
                        PH_RUN: begin
                            if (i_sts.out_free) begin
                                o_cmd.run_emit = 1'b1;
                                n_state        = S_RUN_CRC;
                            end
                        end
                        default: begin
                            n_state = w_after;
                        end
                    endcase
                end
            end
            S_RUN_CRC: begin
                o_cmd.crc_step = 1'b1;
                if (i_sts.crc_cnt_one) begin
                    n_state = i_sts.run_left_zero ? w_after : S_PROC;
                end
            end
            S_STATUS: begin
                if (i_sts.out_free) begin
                    o_cmd.status_emit = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/rledc_datapath.sv */
// Datapath of the run-length decoder: stream state, CRC, configuration and output register.
module rledc_datapath
    import rledc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_in_byte,
    input  logic             i_in_last,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_stall,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    output logic             o_valid,
    output logic [63:0]      o_out_data,
    output logic [3:0]       o_out_count,
    output logic [LEN_W-1:0] o_out_offset,
    output logic             o_out_done,
    output logic [2:0]       o_out_status,
    output logic             o_out_run_last
);

    // One byte of CRC-16, MSB first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Configuration
    logic [LEN_W-1:0] r_output_length;
    logic [CRC_W-1:0] r_expected_crc;
    logic [CRC_W-1:0] r_crc_seed;

    // Stream state
    logic [7:0]       r_byte;
    logic             r_last;
    logic [1:0]       r_phase;
    logic [CNT_W-1:0] r_lit_left;
    logic [CNT_W-1:0] r_run_left;
    logic [LEN_W-1:0] r_wp;
    logic [CRC_W-1:0] r_crc;
    logic [2:0]       r_err;
    logic [3:0]       r_crc_cnt;

    // Output register
    logic             r_valid;
    logic [63:0]      r_data;
    logic [3:0]       r_count;
    logic [LEN_W-1:0] r_offset;
    logic             r_done;
    logic [2:0]       r_status;
    logic             r_run_last;

    logic             w_out_free;
    logic [CNT_W-1:0] w_count;
    logic [LEN_W:0]   w_end;
    logic             w_overflow;
    logic [3:0]       w_group;
    logic [CNT_W-1:0] w_run_after;
    logic [CNT_W-1:0] w_lit_after;
    logic [63:0]      w_group_data;
    logic [2:0]       w_final;
    logic             w_seed_idle;

    assign w_out_free = !r_valid || !i_stall;

    // Command byte decode and overflow check
    assign w_count    = (r_byte & CMD_COUNT_MASK) + 8'd1;
    assign w_end      = {1'b0, r_wp} + (LEN_W + 1)'(w_count);
    assign w_overflow = w_end > {1'b0, r_output_length};

    // Size of the next run group and its lanes
    assign w_group     = (r_run_left < CNT_W'(LANES)) ? r_run_left[3:0] : 4'(LANES);
    assign w_run_after = r_run_left - CNT_W'(w_group);
    assign w_lit_after = (r_lit_left != '0) ? (r_lit_left - 8'd1) : r_lit_left;

    always_comb begin
        w_group_data = '0;
        for (int i = 0; i < LANES; i++) begin
            if (4'(i) < w_group) begin
                w_group_data[8*i +: 8] = r_byte;
            end
        end
    end

    // Final status of the stream
    always_comb begin
        if (r_err != ST_BUSY) begin
            w_final = r_err;
        end else if (r_phase != PH_CMD) begin
            w_final = ST_TRUNC;
        end else if (r_wp != r_output_length) begin
            w_final = ST_LENGTH;
        end else if (r_crc != r_expected_crc) begin
            w_final = ST_CRC;
        end else begin
            w_final = ST_OK;
        end
    end

    assign w_seed_idle = (r_phase == PH_CMD) && (r_wp == '0) && (r_err == ST_BUSY);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_length <= OUTPUT_LENGTH_RST;
            r_expected_crc  <= EXPECTED_CRC_RST;
            r_crc_seed      <= CRC_SEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OUTPUT_LENGTH: r_output_length <= i_cfg_data[LEN_W-1:0];
                REG_EXPECTED_CRC:  r_expected_crc  <= i_cfg_data[CRC_W-1:0];
                REG_CRC_SEED:      r_crc_seed      <= i_cfg_data[CRC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Hold the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte <= i_in_byte;
            r_last <= i_in_last;
        end
    end

    // Stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CMD;
            r_lit_left <= '0;
            r_run_left <= '0;
            r_wp       <= '0;
            r_crc      <= CRC_SEED_RST;
            r_err      <= ST_BUSY;
            r_crc_cnt  <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_index == REG_CRC_SEED) && w_seed_idle) begin
                r_crc <= i_cfg_data[CRC_W-1:0];
            end
            if (i_cmd.cmd_decode) begin
                if (w_overflow) begin
                    r_err <= ST_OVERFLOW;
                end else if ((r_byte & CMD_RUN_FLAG) != '0) begin
                    r_run_left <= w_count;
                    r_phase    <= PH_RUN;
                end else begin
                    r_lit_left <= w_count;
                    r_phase    <= PH_LIT;
                end
            end
            if (i_cmd.lit_emit) begin
                r_crc      <= crc_byte(r_crc, r_byte);
                r_wp       <= r_wp + LEN_W'(1);
                r_lit_left <= w_lit_after;
                if (w_lit_after == '0) begin
                    r_phase <= PH_CMD;
                end
            end
            if (i_cmd.run_emit) begin
                r_wp       <= r_wp + LEN_W'(w_group);
                r_run_left <= w_run_after;
                r_crc_cnt  <= w_group;
                if (w_run_after == '0) begin
                    r_phase <= PH_CMD;
                end
            end
            // One CRC byte per cycle over the run group
            if (i_cmd.crc_step) begin
                r_crc     <= crc_byte(r_crc, r_byte);
                r_crc_cnt <= r_crc_cnt - 4'd1;
            end
            // Restart the stream after its status
            if (i_cmd.status_emit) begin
                r_phase    <= PH_CMD;
                r_lit_left <= '0;
                r_run_left <= '0;
                r_wp       <= '0;
                r_crc      <= r_crc_seed;
                r_err      <= ST_BUSY;
            end
        end
    end

    // Output valid: set on load, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.lit_emit || i_cmd.run_emit || i_cmd.status_emit) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.lit_emit) begin
            r_data     <= {56'd0, r_byte};
            r_count    <= 4'd1;
            r_offset   <= r_wp;
            r_done     <= 1'b0;
            r_status   <= ST_BUSY;
            r_run_last <= !r_last;
        end else if (i_cmd.run_emit) begin
            r_data     <= w_group_data;
            r_count    <= w_group;
            r_offset   <= r_wp;
            r_done     <= 1'b0;
            r_status   <= ST_BUSY;
            r_run_last <= (w_run_after == '0) && !r_last;
        end else if (i_cmd.status_emit) begin
            r_data     <= '0;
            r_count    <= 4'd0;
            r_offset   <= r_wp;
            r_done     <= 1'b1;
            r_status   <= w_final;
            r_run_last <= 1'b1;
        end
    end

    assign o_sts.phase         = r_phase;
    assign o_sts.err_set       = (r_err != ST_BUSY);
    assign o_sts.last          = r_last;
    assign o_sts.run_left_zero = (r_run_left == '0);
    assign o_sts.crc_cnt_one   = (r_crc_cnt == 4'd1);
    assign o_sts.out_free      = w_out_free;

    assign o_valid        = r_valid;
    assign o_out_data     = r_data;
    assign o_out_count    = r_count;
    assign o_out_offset   = r_offset;
    assign o_out_done     = r_done;
    assign o_out_status   = r_status;
    assign o_out_run_last = r_run_last;

endmodule

/* rtl/rle_decoder_with_crc_check.sv */
// Top level of the run-length decoder with CRC-16 check.
//
// Input channel: one encoded byte per transaction (i_in_byte, i_in_last),
// accepted when i_valid is high and o_stall is low. Output channel: one result
// per transaction, offered on o_valid and taken when i_stall is low. A result
// carries up to LANE_BYTES decoded bytes with their destination offset, or, with
// o_out_done set, the final stream status and the decoded byte count.
// Sequence: a command byte or a literal byte is accepted, then processed.
// A run value byte is accepted, then each group of up to LANE_BYTES bytes is
// emitted and folded into the CRC, which takes in one byte per cycle; a full
// run is 128 bytes. The final byte adds a status result.
// The output register lets the next input be taken while a result waits.
// A stall on the output holds the result and halts the sequencer only when a
// further result is ready to be loaded.
// Reset (synchronous, active low) restores the register defaults and the
// start-of-stream state. Configuration writes are taken at any edge with
// i_cfg_we high; a seed write also loads the running CRC at stream start.
module rle_decoder_with_crc_check
    import rledc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_in_byte,
    input  logic             i_in_last,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [63:0]      o_out_data,
    output logic [3:0]       o_out_count,
    output logic [LEN_W-1:0] o_out_offset,
    output logic             o_out_done,
    output logic [2:0]       o_out_status,
    output logic             o_out_run_last
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer
    rledc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Datapath and output register
    rledc_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_byte      (i_in_byte),
        .i_in_last      (i_in_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_stall        (i_stall),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_valid        (o_valid),
        .o_out_data     (o_out_data),
        .o_out_count    (o_out_count),
        .o_out_offset   (o_out_offset),
        .o_out_done     (o_out_done),
        .o_out_status   (o_out_status),
        .o_out_run_last (o_out_run_last)
    );

    // An accepted transaction keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken twice in consecutive cycles");

    // A status result carries no bytes and closes its transaction
    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_done) |-> (o_out_run_last && (o_out_count == 4'd0)
                                     && (o_out_status != ST_BUSY)))
        else $error("malformed status result");

    // A data result holds one to LANES bytes and reports busy
    a_data_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_done) |-> ((o_out_count != 4'd0)
                                      && (o_out_count <= 4'(LANES))
                                      && (o_out_status == ST_BUSY)))
        else $error("malformed data result");

endmodule
